/* rtl/pad_serial_command_responder_macros.svh */
// assertion macros of the pad serial command responder rtl
`ifndef PAD_SERIAL_COMMAND_RESPONDER_MACROS_SVH
`define PAD_SERIAL_COMMAND_RESPONDER_MACROS_SVH

`ifndef SYNTHESIS

`define PSCR_ASSERT_HOLDS(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pscr check failed in the same cycle");

`define PSCR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pscr check failed in the following cycle");

`else

`define PSCR_ASSERT_HOLDS(name, clk, rst, ante, cons)

`define PSCR_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

/* rtl/pscr_pkg.sv */
// types and constants of the pad serial command responder
package pscr_pkg;

   localparam int REPLY_BYTES = 8;
   localparam int MAP_ENTRIES = 5;

   typedef struct packed {
      logic [1:0]        func;
      logic [7:0]        rx_byte;
      logic [15:0]       button_bits;
      logic signed [7:0] steering;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       ack;
      logic       motor_strobe;
      logic [7:0] motor_byte;
      logic       wheel_mode;
      logic       config_active;
   } rsp_type;

   // item functions
   localparam logic [1:0] FUNC_XCHG = 2'd0;
   localparam logic [1:0] FUNC_END  = 2'd1;
   localparam logic [1:0] FUNC_MODE = 2'd2;

   // host bytes
   localparam logic [7:0] BYTE_ATTN     = 8'h01;
   localparam logic [7:0] CMD_POLL      = 8'h42;
   localparam logic [7:0] CMD_CONFIG    = 8'h43;
   localparam logic [7:0] CMD_SET_MODE  = 8'h44;
   localparam logic [7:0] CMD_GET_MODE  = 8'h45;
   localparam logic [7:0] CMD_QUERY_46  = 8'h46;
   localparam logic [7:0] CMD_QUERY_47  = 8'h47;
   localparam logic [7:0] CMD_QUERY_4C  = 8'h4C;
   localparam logic [7:0] CMD_MOTOR_MAP = 8'h4D;

   // reply bytes
   localparam logic [7:0] ID_CONFIG  = 8'hF3;
   localparam logic [7:0] ID_WHEEL   = 8'hE3;
   localparam logic [7:0] ID_DIGITAL = 8'h41;
   localparam logic [7:0] STATUS_OK  = 8'h5A;
   localparam logic [7:0] BYTE_NONE  = 8'hFF;
   localparam logic [7:0] MAP_UNUSED = 8'hFF;
   localparam logic [7:0] Q46_TAIL_0 = 8'h0A;
   localparam logic [7:0] Q46_TAIL_1 = 8'h14;

endpackage

/* rtl/pad_serial_command_responder.sv */
// Device side of a game-pad serial exchange, one host byte per item. An item
// is registered at the input, decoded against the command state in one pass
// and its result registered at the output, so the block takes one item every
// cycle unless a stalled output holds the input register; a result is held in
// the output register until taken. Each side has one register, so an
// item can be taken while the previous result still waits. Items of function 0
// exchange a byte, 1 ends the transfer, 2 presses the mode button (queued while
// a transfer is busy). Replies are 8 bytes in wheel mode and 4 in digital mode;
// motor command bytes come out on motor_strobe and motor_byte.
module pad_serial_command_responder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pscr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pscr_pkg::rsp_type rsp_data
);

   logic              in_valid_ff, in_valid_in;
   pscr_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   pscr_pkg::rsp_type out_data_ff;
   pscr_pkg::rsp_type result;
   logic              out_free;
   logic              fire;
   logic              accept;

   // output slot is free when empty or being taken this cycle
   assign out_free = ~out_valid_ff | ~rsp_stall;
   assign fire     = in_valid_ff & out_free;
   assign req_stall = in_valid_ff & ~out_free;
   assign accept   = req_valid & ~req_stall;

   assign in_valid_in  = accept | (in_valid_ff & ~fire);
   assign out_valid_in = fire | (out_valid_ff & rsp_stall);

   pscr_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* rtl/pscr_engine.sv */
// command decode, reply buffer and motor map of the pad responder, one item per pass
`include "pad_serial_command_responder_macros.svh"

module pscr_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  pscr_pkg::req_type item,
   output pscr_pkg::rsp_type result
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READY,
      ST_POLL,
      ST_SETCFG,
      ST_SETMODE,
      ST_GETMODE,
      ST_Q46,
      ST_Q47,
      ST_Q4C,
      ST_MAP
   } state_type;

   state_type         state_ff, state_in;
   logic [2:0]        step_ff, step_in;
   logic              long_ff, long_in;
   logic [7:0]        buf_ff [pscr_pkg::REPLY_BYTES];
   logic [7:0]        buf_in [pscr_pkg::REPLY_BYTES];
   logic [7:0]        rx_third_ff, rx_third_in;
   logic [7:0]        map_ff [pscr_pkg::MAP_ENTRIES];
   logic [7:0]        map_in [pscr_pkg::MAP_ENTRIES];
   logic              wheel_ff, wheel_in;
   logic              cfg_ff, cfg_in;
   logic signed [7:0] prev_steer_ff, prev_steer_in;
   logic [3:0]        nibble_ff, nibble_in;
   logic              pending_ff, pending_in;

   logic              emit;
   logic              start;
   logic              do_poll;
   logic [5:0][7:0]   tail;
   logic [7:0]        id_byte;
   logic [2:0]        map_idx;
   logic              in_map;
   logic [7:0]        map_sel;
   logic              any_zero;
   logic [1:0]        rot;
   logic              wrap;
   logic [7:0]        tx;
   logic              ack;
   logic              strobe;
   logic [7:0]        motor;

   assign map_idx = step_ff - 3'd2;
   assign in_map  = (step_ff >= 3'd2) && (step_ff <= 3'd6);
   assign id_byte = cfg_ff ? pscr_pkg::ID_CONFIG :
                    (wheel_ff ? pscr_pkg::ID_WHEEL : pscr_pkg::ID_DIGITAL);

   always_comb begin
      map_sel  = '0;
      any_zero = 1'b0;
      for (int i = 0; i < pscr_pkg::MAP_ENTRIES; i++) begin
         if (map_idx == 3'(i)) begin
            map_sel = map_ff[i];
         end
         if (map_ff[i] == 8'h00) begin
            any_zero = 1'b1;
         end
      end
   end

   always_comb begin
      if (item.steering > prev_steer_ff) begin
         rot = 2'd1;
      end else if (item.steering < prev_steer_ff) begin
         rot = 2'd2;
      end else begin
         rot = 2'd0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      long_in       = long_ff;
      buf_in        = buf_ff;
      rx_third_in   = rx_third_ff;
      map_in        = map_ff;
      wheel_in      = wheel_ff;
      cfg_in        = cfg_ff;
      prev_steer_in = prev_steer_ff;
      nibble_in     = nibble_ff;
      pending_in    = pending_ff;
      emit          = 1'b0;
      start         = 1'b0;
      do_poll       = 1'b0;
      tail          = '0;
      wrap          = 1'b0;
      tx            = pscr_pkg::BYTE_NONE;
      ack           = 1'b0;
      strobe        = 1'b0;
      motor         = 8'h00;

      if (fire) begin
         case (item.func)
            pscr_pkg::FUNC_END: begin
               if (pending_ff) begin
                  wheel_in   = ~wheel_ff;
                  cfg_in     = cfg_ff & ~wheel_ff;
                  pending_in = 1'b0;
               end
               state_in = ST_IDLE;
               step_in  = 3'd0;
            end
            pscr_pkg::FUNC_MODE: begin
               if (state_ff == ST_IDLE) begin
                  wheel_in = ~wheel_ff;
                  cfg_in   = cfg_ff & ~wheel_ff;
               end else begin
                  pending_in = 1'b1;
               end
            end
            pscr_pkg::FUNC_XCHG: begin
               if (step_ff == 3'd2) begin
                  rx_third_in = item.rx_byte;
               end
               emit = 1'b1;
               case (state_ff)
                  ST_IDLE: begin
                     emit = 1'b0;
                     if (item.rx_byte == pscr_pkg::BYTE_ATTN) begin
                        state_in    = ST_READY;
                        rx_third_in = 8'h00;
                        ack         = 1'b1;
                        for (int i = 0; i < pscr_pkg::REPLY_BYTES; i++) begin
                           buf_in[i] = 8'h00;
                        end
                     end
                  end
                  ST_READY: begin
                     case (item.rx_byte)
                        pscr_pkg::CMD_POLL: begin
                           start    = 1'b1;
                           do_poll  = 1'b1;
                           state_in = ST_POLL;
                        end
                        pscr_pkg::CMD_CONFIG: begin
                           if (wheel_ff) begin
                              start    = 1'b1;
                              do_poll  = 1'b1;
                              state_in = ST_SETCFG;
                           end
                        end
                        pscr_pkg::CMD_SET_MODE: begin
                           if (cfg_ff) begin
                              start     = 1'b1;
                              state_in  = ST_SETMODE;
                              strobe    = 1'b1;
                              nibble_in = 4'd0;
                              for (int i = 0; i < pscr_pkg::MAP_ENTRIES; i++) begin
                                 map_in[i] = pscr_pkg::MAP_UNUSED;
                              end
                           end
                        end
                        pscr_pkg::CMD_GET_MODE: begin
                           if (cfg_ff) begin
                              start    = 1'b1;
                              state_in = ST_GETMODE;
                              tail     = {8'h00, 8'h01, 8'h01, {7'd0, wheel_ff}, 8'h02, 8'h01};
                           end
                        end
                        pscr_pkg::CMD_QUERY_46: begin
                           if (cfg_ff) begin
                              start    = 1'b1;
                              state_in = ST_Q46;
                           end
                        end
                        pscr_pkg::CMD_QUERY_47: begin
                           if (cfg_ff) begin
                              start    = 1'b1;
                              state_in = ST_Q47;
                              tail     = {8'h00, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00};
                           end
                        end
                        pscr_pkg::CMD_QUERY_4C: begin
                           if (cfg_ff) begin
                              start    = 1'b1;
                              state_in = ST_Q4C;
                           end
                        end
                        pscr_pkg::CMD_MOTOR_MAP: begin
                           if (cfg_ff) begin
                              start    = 1'b1;
                              state_in = ST_MAP;
                           end
                        end
                        default: begin
                        end
                     endcase
                     if (start) begin
                        long_in   = wheel_ff;
                        buf_in[0] = id_byte;
                        buf_in[1] = pscr_pkg::STATUS_OK;
                        for (int i = 0; i < 6; i++) begin
                           buf_in[i + 2] = tail[i];
                        end
                        if (do_poll) begin
                           buf_in[2]     = item.button_bits[7:0];
                           buf_in[3]     = item.button_bits[15:8];
                           buf_in[4]     = item.steering;
                           buf_in[5]     = {8{item.steering[7]}};
                           buf_in[6]     = {nibble_ff, 2'b00, rot};
                           prev_steer_in = item.steering;
                        end
                     end else begin
                        // unknown or refused command: keep waiting for one
                        emit = 1'b0;
                     end
                  end
                  ST_POLL: begin
                     if (in_map && (map_sel == 8'h00)) begin
                        strobe    = 1'b1;
                        motor     = item.rx_byte;
                        nibble_in = item.rx_byte[7:4];
                     end
                  end
                  ST_SETMODE: begin
                     if ((step_ff == 3'd2) && (item.rx_byte[7:1] == 7'd0)) begin
                        wheel_in = item.rx_byte[0];
                        cfg_in   = cfg_ff & item.rx_byte[0];
                     end
                  end
                  ST_SETCFG: begin
                     // uses the third host byte, which may arrive in this very item
                     cfg_in = (rx_third_in == 8'h01) && wheel_ff;
                  end
                  ST_MAP: begin
                     if (in_map) begin
                        buf_in[step_ff] = map_sel;
                        for (int i = 0; i < pscr_pkg::MAP_ENTRIES; i++) begin
                           if (map_idx == 3'(i)) begin
                              map_in[i] = item.rx_byte;
                           end
                        end
                     end else if (!any_zero) begin
                        strobe    = 1'b1;
                        nibble_in = 4'd0;
                     end
                  end
                  ST_Q46: begin
                     if (step_ff == 3'd2) begin
                        if (item.rx_byte == 8'h00) begin
                           buf_in[4] = 8'h01;
                           buf_in[5] = 8'h02;
                           buf_in[6] = 8'h00;
                           buf_in[7] = pscr_pkg::Q46_TAIL_0;
                        end else if (item.rx_byte == 8'h01) begin
                           buf_in[4] = 8'h01;
                           buf_in[5] = 8'h01;
                           buf_in[6] = 8'h01;
                           buf_in[7] = pscr_pkg::Q46_TAIL_1;
                        end
                     end
                  end
                  ST_Q47: begin
                     if ((step_ff == 3'd2) && (item.rx_byte != 8'h00)) begin
                        buf_in[4] = 8'h00;
                        buf_in[5] = 8'h00;
                        buf_in[6] = 8'h00;
                        buf_in[7] = 8'h00;
                     end
                  end
                  ST_Q4C: begin
                     if (step_ff == 3'd2) begin
                        if (item.rx_byte == 8'h00) begin
                           buf_in[5] = 8'h04;
                        end else if (item.rx_byte == 8'h01) begin
                           buf_in[4] = 8'h03;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               if (emit) begin
                  tx      = buf_in[step_ff];
                  wrap    = long_in ? (step_ff == 3'd7) : (step_ff == 3'd3);
                  step_in = wrap ? 3'd0 : step_ff + 3'd1;
                  ack     = ~wrap;
                  if (wrap) begin
                     state_in = ST_IDLE;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign result.tx_byte       = tx;
   assign result.ack           = ack;
   assign result.motor_strobe  = strobe;
   assign result.motor_byte    = motor;
   assign result.wheel_mode    = wheel_in;
   assign result.config_active = cfg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= 3'd0;
         long_ff       <= 1'b1;
         rx_third_ff   <= 8'h00;
         wheel_ff      <= 1'b1;
         cfg_ff        <= 1'b0;
         prev_steer_ff <= 8'sd0;
         nibble_ff     <= 4'd0;
         pending_ff    <= 1'b0;
         for (int i = 0; i < pscr_pkg::REPLY_BYTES; i++) begin
            buf_ff[i] <= 8'h00;
         end
         for (int i = 0; i < pscr_pkg::MAP_ENTRIES; i++) begin
            map_ff[i] <= pscr_pkg::MAP_UNUSED;
         end
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         long_ff       <= long_in;
         rx_third_ff   <= rx_third_in;
         wheel_ff      <= wheel_in;
         cfg_ff        <= cfg_in;
         prev_steer_ff <= prev_steer_in;
         nibble_ff     <= nibble_in;
         pending_ff    <= pending_in;
         buf_ff        <= buf_in;
         map_ff        <= map_in;
      end
   end

   `PSCR_ASSERT_HOLDS(a_cfg_needs_wheel, clock, reset, cfg_ff, wheel_ff)
   `PSCR_ASSERT_HOLDS(a_step_only_in_reply, clock, reset, step_ff != 3'd0, state_ff != ST_IDLE && state_ff != ST_READY)
   `PSCR_ASSERT_HOLDS(a_short_reply_steps, clock, reset, !long_ff, step_ff[2] == 1'b0)
   `PSCR_ASSERT_NEXT(a_end_returns_idle, clock, reset, fire && item.func == pscr_pkg::FUNC_END, state_ff == ST_IDLE && step_ff == 3'd0 && !pending_ff)

endmodule
